// ===== hdl/r2fft_pkg.sv =====
// Shared constants, types and the twiddle table for the radix-2 FFT.
// Standalone package; used by radix2_complex_fft.
package r2fft_pkg;

  localparam int FFT_POINTS = 1024;
  localparam int ADDR_W     = $clog2(FFT_POINTS);
  localparam int HALF_W     = ADDR_W - 1;
  localparam int STG_W      = $clog2(ADDR_W + 1);
  localparam int QUARTER    = FFT_POINTS / 4;
  localparam int QIDX_W     = (QUARTER > 1) ? $clog2(QUARTER) : 1;

  localparam int IDX_W      = 10;
  localparam int SAMP_W     = 24;
  localparam int DATA_W     = 38;
  localparam int TW_W       = 19;
  localparam int PROD_W     = DATA_W + TW_W;
  localparam int RND_SH     = 17;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_RUN  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam longint unsigned PI_Q31  = 64'd6746518852;
  localparam longint unsigned ONE_Q31 = 64'd2147483648;

  // One table row: {cos, sin} of the first quadrant, Q1.17
  typedef logic [2*TW_W-1:0] tw_entry_t;
  typedef tw_entry_t tw_table_t [QUARTER];

  function automatic longint unsigned mul_q31(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 30)) >> 31;
  endfunction

  function automatic longint unsigned sin_q31(longint unsigned x);
    longint unsigned x2, term, sum;
    x2   = mul_q31(x, x);
    term = x;
    sum  = x;
    term = (mul_q31(term, x2) + 64'd3) / 64'd6;    sum = sum - term;
    term = (mul_q31(term, x2) + 64'd10) / 64'd20;  sum = sum + term;
    term = (mul_q31(term, x2) + 64'd21) / 64'd42;  sum = sum - term;
    term = (mul_q31(term, x2) + 64'd36) / 64'd72;  sum = sum + term;
    term = (mul_q31(term, x2) + 64'd55) / 64'd110; sum = sum - term;
    term = (mul_q31(term, x2) + 64'd78) / 64'd156; sum = sum + term;
    return sum;
  endfunction

  function automatic longint unsigned cos_q31(longint unsigned x);
    longint unsigned x2, term, sum;
    x2   = mul_q31(x, x);
    term = ONE_Q31;
    sum  = ONE_Q31;
    term = (mul_q31(term, x2) + 64'd1) / 64'd2;    sum = sum - term;
    term = (mul_q31(term, x2) + 64'd6) / 64'd12;   sum = sum + term;
    term = (mul_q31(term, x2) + 64'd15) / 64'd30;  sum = sum - term;
    term = (mul_q31(term, x2) + 64'd28) / 64'd56;  sum = sum + term;
    term = (mul_q31(term, x2) + 64'd45) / 64'd90;  sum = sum - term;
    term = (mul_q31(term, x2) + 64'd66) / 64'd132; sum = sum + term;
    term = (mul_q31(term, x2) + 64'd91) / 64'd182; sum = sum - term;
    return sum;
  endfunction

  function automatic logic [TW_W-1:0] to_q17(longint unsigned v);
    longint unsigned t;
    t = (v + 64'd8192) >> 14;
    return t[TW_W-1:0];
  endfunction

  // Fold each angle into the first octant, then swap sin and cos above it
  function automatic tw_table_t build_tw();
    tw_table_t       tbl;
    longint unsigned rr, x;
    logic [TW_W-1:0] c, s;
    for (int r = 0; r < QUARTER; r++) begin
      rr = (2 * r <= QUARTER) ? longint'(r) : longint'(QUARTER - r);
      x  = (64'd2 * PI_Q31 * rr + FFT_POINTS / 2) / FFT_POINTS;
      if (2 * r <= QUARTER) begin
        c = to_q17(cos_q31(x));
        s = to_q17(sin_q31(x));
      end else begin
        c = to_q17(sin_q31(x));
        s = to_q17(cos_q31(x));
      end
      tbl[r] = {c, s};
    end
    return tbl;
  endfunction

  localparam tw_table_t TW_ROM = build_tw();

  function automatic logic [ADDR_W-1:0] bit_rev(logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    for (int i = 0; i < ADDR_W; i++) begin
      r[i] = v[ADDR_W-1-i];
    end
    return r;
  endfunction

endpackage

// ===== hdl/r2fft_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module r2fft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/radix2_complex_fft.sv =====
// In-place radix-2 DIT complex FFT top level: sequencer, butterfly datapath, I/O.
// Depends on r2fft_pkg and r2fft_ram.
// Load: one transfer per cycle while idle. Read: the bin passes the registered read port,
// then the output register once it is free. Transform: each index at or below its bit
// reversal is swapped, others skipped, then (N/2)*log2(N) butterflies on one store port.
// Reset (synchronous, rst_n low): direction forward, idle, no result; RAM contents undefined.
module radix2_complex_fft (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              in_action,
  input  logic [r2fft_pkg::IDX_W-1:0]             in_index,
  input  logic signed [r2fft_pkg::SAMP_W-1:0]     in_sample_re,
  input  logic signed [r2fft_pkg::SAMP_W-1:0]     in_sample_im,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [r2fft_pkg::DATA_W-1:0]     out_bin_re,
  output logic signed [r2fft_pkg::DATA_W-1:0]     out_bin_im,
  output logic                                    out_done_res,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic                                    cfg_direction
);

  localparam int AW = r2fft_pkg::ADDR_W;
  localparam int DW = r2fft_pkg::DATA_W;
  localparam int TW = r2fft_pkg::TW_W;
  localparam int PW = r2fft_pkg::PROD_W;
  localparam int SW = r2fft_pkg::STG_W;
  localparam int SH = r2fft_pkg::RND_SH;

  typedef enum logic [3:0] {
    S_IDLE, S_RDOUT,
    S_BR_RD_J, S_BR_RD_R, S_BR_WJ, S_BR_WR,
    S_BF_RD_B, S_BF_RD_A, S_BF_M1, S_BF_M2, S_BF_SUM, S_BF_WA, S_BF_WB,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   dir_r;
  logic   out_valid_r;

  logic [AW-1:0]                    j_r;
  logic [r2fft_pkg::HALF_W-1:0]     bf_r;
  logic [SW-1:0]                    stage_r;

  logic signed [DW-1:0] a_re_r, a_im_r, b_re_r, b_im_r, p_re_r, p_im_r;
  logic signed [TW-1:0] wr_r, wi_r;
  logic signed [PW-1:0] ma_r, mb_r;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [2*DW-1:0]   ram_wdata, ram_rdata;

  logic              in_fire, out_free, out_load;
  logic [AW-1:0]     in_addr, rev_j;
  logic              j_last, bf_last, stage_last;
  logic [AW-1:0]     half, lowmask, bfw, a_addr, b_addr, tw_k;
  logic [SW-1:0]     tw_sh;
  logic [r2fft_pkg::QIDX_W-1:0] tw_m;
  r2fft_pkg::tw_entry_t         tw_ent;
  logic signed [TW-1:0] tw_c, tw_s, cos_v, sin_v;
  logic signed [DW-1:0] rd_re, rd_im, mul_x, mul_y;
  logic signed [PW-1:0] prod_a, prod_b;
  logic signed [PW:0]   sum_re, sum_im;
  logic signed [DW-1:0] ld_re, ld_im;

  // Sample store: {real, imag} per entry
  r2fft_ram #(
    .WIDTH (2 * DW),
    .DEPTH (r2fft_pkg::FFT_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_re = ram_rdata[2*DW-1:DW];
  assign rd_im = ram_rdata[DW-1:0];

  // Handshakes
  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  assign in_addr = AW'(32'(in_index) % r2fft_pkg::FFT_POINTS);
  assign ld_re   = {{(DW - r2fft_pkg::SAMP_W){in_sample_re[r2fft_pkg::SAMP_W-1]}}, in_sample_re};
  assign ld_im   = {{(DW - r2fft_pkg::SAMP_W){in_sample_im[r2fft_pkg::SAMP_W-1]}}, in_sample_im};

  // Counter positions
  assign rev_j      = r2fft_pkg::bit_rev(j_r);
  assign j_last     = (j_r == AW'(r2fft_pkg::FFT_POINTS - 1));
  assign bf_last    = (bf_r == '1);
  assign stage_last = (stage_r == SW'(AW));

  // Butterfly pair addresses: insert a zero at the stage's bit position
  assign half    = AW'(1) << (stage_r - SW'(1));
  assign lowmask = half - AW'(1);
  assign bfw     = AW'(bf_r);
  assign a_addr  = ((bfw & ~lowmask) << 1) | (bfw & lowmask);
  assign b_addr  = a_addr | half;

  // Twiddle: quarter-wave table, second quadrant by rotation
  assign tw_sh  = SW'(AW) - stage_r;
  assign tw_k   = (bfw & lowmask) << tw_sh;
  assign tw_m   = r2fft_pkg::QIDX_W'(32'(tw_k) % r2fft_pkg::QUARTER);
  assign tw_ent = r2fft_pkg::TW_ROM[tw_m];
  assign tw_c   = tw_ent[2*TW-1:TW];
  assign tw_s   = tw_ent[TW-1:0];
  assign cos_v  = tw_k[AW-2] ? -tw_s : tw_c;
  assign sin_v  = tw_k[AW-2] ? tw_c : tw_s;

  // Two shared multipliers, cross products in the second pass
  assign mul_x  = (state_r == S_BF_M1) ? b_re_r : b_im_r;
  assign mul_y  = (state_r == S_BF_M1) ? b_im_r : b_re_r;
  assign prod_a = mul_x * wr_r;
  assign prod_b = mul_y * wi_r;

  // Round half up at 2^-17
  assign sum_re = {ma_r[PW-1], ma_r} - {mb_r[PW-1], mb_r} + (PW+1)'(65536);
  assign sum_im = {ma_r[PW-1], ma_r} + {mb_r[PW-1], mb_r} + (PW+1)'(65536);

  // Sequencer and RAM port control
  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_waddr = j_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = j_r;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_action)
            r2fft_pkg::ACT_LOAD: begin
              ram_we    = 1'b1;
              ram_waddr = in_addr;
              ram_wdata = {ld_re, ld_im};
            end
            r2fft_pkg::ACT_RUN: begin
              state_nxt = S_BR_RD_J;
            end
            r2fft_pkg::ACT_READ: begin
              ram_re    = 1'b1;
              ram_raddr = in_addr;
              state_nxt = S_RDOUT;
            end
            default: ;
          endcase
        end
      end
      S_RDOUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_BR_RD_J: begin
        if (j_r <= rev_j) begin
          ram_re    = 1'b1;
          ram_raddr = j_r;
          state_nxt = S_BR_RD_R;
        end else if (j_last) begin
          state_nxt = S_BF_RD_B;
        end
      end
      S_BR_RD_R: begin
        ram_re    = 1'b1;
        ram_raddr = rev_j;
        state_nxt = S_BR_WJ;
      end
      S_BR_WJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = {rd_re, dir_r ? rd_im : DW'(0)};
        state_nxt = S_BR_WR;
      end
      S_BR_WR: begin
        ram_we    = 1'b1;
        ram_waddr = rev_j;
        ram_wdata = {a_re_r, dir_r ? a_im_r : DW'(0)};
        state_nxt = j_last ? S_BF_RD_B : S_BR_RD_J;
      end
      S_BF_RD_B: begin
        ram_re    = 1'b1;
        ram_raddr = b_addr;
        state_nxt = S_BF_RD_A;
      end
      S_BF_RD_A: begin
        ram_re    = 1'b1;
        ram_raddr = a_addr;
        state_nxt = S_BF_M1;
      end
      S_BF_M1:  state_nxt = S_BF_M2;
      S_BF_M2:  state_nxt = S_BF_SUM;
      S_BF_SUM: state_nxt = S_BF_WA;
      S_BF_WA: begin
        ram_we    = 1'b1;
        ram_waddr = a_addr;
        ram_wdata = {DW'(a_re_r + p_re_r), DW'(a_im_r + p_im_r)};
        state_nxt = S_BF_WB;
      end
      S_BF_WB: begin
        ram_we    = 1'b1;
        ram_waddr = b_addr;
        ram_wdata = {DW'(a_re_r - p_re_r), DW'(a_im_r - p_im_r)};
        state_nxt = (bf_last && stage_last) ? S_DONE : S_BF_RD_B;
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, counters, direction and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      bf_r        <= '0;
      stage_r     <= SW'(1);
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        dir_r <= cfg_direction;
      end
      if (out_load) begin
        out_valid_r  <= 1'b1;
        out_done_res <= (state_r == S_DONE);
        out_bin_re   <= (state_r == S_DONE) ? DW'(0) : rd_re;
        out_bin_im   <= (state_r == S_DONE) ? DW'(0) : rd_im;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire && in_action == r2fft_pkg::ACT_RUN) begin
        j_r     <= '0;
        bf_r    <= '0;
        stage_r <= SW'(1);
      end
      // Advance the bit-reversal index on skip or after a swap
      if ((state_r == S_BR_RD_J && j_r > rev_j) || state_r == S_BR_WR) begin
        j_r <= j_r + AW'(1);
      end
      // Advance the butterfly within the stage, then the stage
      if (state_r == S_BF_WB) begin
        bf_r <= bf_r + 1'b1;
        if (bf_last) begin
          stage_r <= stage_r + SW'(1);
        end
      end
    end
  end

  // Butterfly datapath
  always_ff @(posedge clk) begin
    if (state_r == S_BR_RD_R) begin
      a_re_r <= rd_re;
      a_im_r <= rd_im;
    end
    if (state_r == S_BF_RD_B) begin
      wr_r <= cos_v;
      wi_r <= dir_r ? sin_v : -sin_v;
    end
    if (state_r == S_BF_RD_A) begin
      b_re_r <= rd_re;
      b_im_r <= rd_im;
    end
    if (state_r == S_BF_M1) begin
      a_re_r <= rd_re;
      a_im_r <= rd_im;
    end
    if (state_r == S_BF_M1 || state_r == S_BF_M2) begin
      ma_r <= prod_a;
      mb_r <= prod_b;
    end
    if (state_r == S_BF_M2) begin
      p_re_r <= sum_re[SH+DW-1:SH];
    end
    if (state_r == S_BF_SUM) begin
      p_im_r <= sum_im[SH+DW-1:SH];
    end
  end

  // Reads and writes of the store never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store read and write in the same cycle");

  // A transform transfer locks the input until the sequence ends
  a_run_locks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_action == r2fft_pkg::ACT_RUN) |=> in_stall)
    else $error("input taken during transform");

  // Bin read data lands in the output register as read data
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDOUT && out_free) |=> (out_valid && !out_done_res))
    else $error("bin read result missing");

  // The lower butterfly write always targets the upper half of the pair
  a_pair_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BF_WB) |-> ((ram_waddr & half) != '0))
    else $error("butterfly pair address broken");

endmodule

// ===== tb/sv/radix2_complex_fft_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for radix2_complex_fft: loads frames, runs forward and inverse
// transforms and reads bins back, checking every result against an in-bench FFT model.
// Depends on r2fft_pkg and the radix2_complex_fft RTL.
module radix2_complex_fft_tb;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int N_PTS = r2fft_pkg::FFT_POINTS;
  localparam int LIMIT_CYCLES = 2000000;
  localparam longint SMAX = 64'sd8388607;
  localparam longint SMIN = -64'sd8388608;

  typedef struct {
    logic [1:0]                          action;
    logic [r2fft_pkg::IDX_W-1:0]         index;
    logic signed [r2fft_pkg::SAMP_W-1:0] re;
    logic signed [r2fft_pkg::SAMP_W-1:0] im;
  } fft_op_t;

  typedef struct {
    logic signed [r2fft_pkg::DATA_W-1:0] re;
    logic signed [r2fft_pkg::DATA_W-1:0] im;
    logic                                done;
  } bin_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = r2fft_pkg::ACT_LOAD;
  logic [r2fft_pkg::IDX_W-1:0] in_index = '0;
  logic signed [r2fft_pkg::SAMP_W-1:0] in_sample_re = '0;
  logic signed [r2fft_pkg::SAMP_W-1:0] in_sample_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [r2fft_pkg::DATA_W-1:0] out_bin_re;
  logic signed [r2fft_pkg::DATA_W-1:0] out_bin_im;
  logic out_done_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_direction = 1'b0;

  fft_op_t  pending_ops[$];
  bin_res_t bin_expect_q[$];
  longint   spec_re[N_PTS];
  longint   spec_im[N_PTS];
  longint   tw_cos[N_PTS];
  longint   tw_sin[N_PTS];
  bit       inv_dir = 1'b0;
  bit       in_took = 1'b0;
  int       errors = 0;
  int       ops_sent = 0;
  int       bins_seen = 0;
  longint   cycles = 0;

  radix2_complex_fft DUT (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned q31_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 30)) >> 31;
  endfunction

  // Taylor series in Q31, rounding each term to nearest
  function automatic longint unsigned q31_series(longint unsigned x, bit want_cos);
    longint unsigned x2, term, sum, dv;
    x2   = q31_mul(x, x);
    term = want_cos ? r2fft_pkg::ONE_Q31 : x;
    sum  = term;
    for (int n = 1; n <= (want_cos ? 7 : 6); n++) begin
      dv   = want_cos ? longint'((2*n-1)*(2*n)) : longint'((2*n)*(2*n+1));
      term = (q31_mul(term, x2) + dv / 2) / dv;
      sum  = (n % 2) ? sum - term : sum + term;
    end
    return sum;
  endfunction

  function automatic longint round_q17(longint v);
    return (v + 64'sd65536) >>> 17;
  endfunction

  function automatic longint wrap_data(longint v);
    logic signed [r2fft_pkg::DATA_W-1:0] w;
    w = v[r2fft_pkg::DATA_W-1:0];
    return longint'(w);
  endfunction

  // Bit-reverse reorder, then all butterfly stages, in place
  function automatic void run_fft_model();
    int bits, r, half, stride, a, b, w;
    longint t, wr, wi, br, bim, pr, pim, ar, ai;
    bits = $clog2(N_PTS);
    if (!inv_dir) begin
      for (int j = 0; j < N_PTS; j++) spec_im[j] = 0;
    end
    for (int j = 0; j < N_PTS; j++) begin
      r = 0;
      for (int k = 0; k < bits; k++) r = (r << 1) | ((j >> k) & 1);
      if (j < r) begin
        t = spec_re[j]; spec_re[j] = spec_re[r]; spec_re[r] = t;
        t = spec_im[j]; spec_im[j] = spec_im[r]; spec_im[r] = t;
      end
    end
    for (int len = 2; len <= N_PTS; len *= 2) begin
      half = len / 2;
      stride = N_PTS / len;
      for (int base = 0; base < N_PTS; base += len) begin
        for (int v = 0; v < half; v++) begin
          a = base + v;
          b = a + half;
          w = (v * stride) % N_PTS;
          wr = tw_cos[w];
          wi = inv_dir ? tw_sin[w] : -tw_sin[w];
          br = spec_re[b];
          bim = spec_im[b];
          pr = round_q17(br * wr - bim * wi);
          pim = round_q17(bim * wr + br * wi);
          ar = spec_re[a];
          ai = spec_im[a];
          spec_re[a] = wrap_data(ar + pr);
          spec_im[a] = wrap_data(ai + pim);
          spec_re[b] = wrap_data(ar - pr);
          spec_im[b] = wrap_data(ai - pim);
        end
      end
    end
  endfunction

  // Update the frame model for one accepted transfer and queue its result
  function automatic void apply_fft_op(fft_op_t op);
    bin_res_t res;
    int idx;
    idx = op.index % N_PTS;
    case (op.action)
      r2fft_pkg::ACT_LOAD: begin
        spec_re[idx] = longint'(op.re);
        spec_im[idx] = longint'(op.im);
      end
      r2fft_pkg::ACT_RUN: begin
        run_fft_model();
        res.re = '0; res.im = '0; res.done = 1'b1;
        bin_expect_q = {bin_expect_q, res};
      end
      r2fft_pkg::ACT_READ: begin
        res.re = spec_re[idx][r2fft_pkg::DATA_W-1:0];
        res.im = spec_im[idx][r2fft_pkg::DATA_W-1:0];
        res.done = 1'b0;
        bin_expect_q = {bin_expect_q, res};
      end
      default: ;
    endcase
  endfunction

  task automatic push_op(logic [1:0] act, int idx, longint re, longint im);
    fft_op_t op;
    op.action = act;
    op.index = idx[r2fft_pkg::IDX_W-1:0];
    op.re = re[r2fft_pkg::SAMP_W-1:0];
    op.im = im[r2fft_pkg::SAMP_W-1:0];
    pending_ops = {pending_ops, op};
  endtask

  // Fill every entry so no read or transform ever touches unwritten storage
  task automatic load_frame(bit with_extremes);
    longint re, im;
    for (int i = 0; i < N_PTS; i++) begin
      re = longint'($signed($urandom_range(0, 32'hFFFFFF) << 8)) >>> 8;
      im = longint'($signed($urandom_range(0, 32'hFFFFFF) << 8)) >>> 8;
      if (with_extremes && i < 4) begin
        re = (i % 2) ? SMIN : SMAX;
        im = (i < 2) ? SMIN : SMAX;
      end
      if (with_extremes && i == N_PTS - 1) begin
        re = SMIN;
        im = SMAX;
      end
      push_op(r2fft_pkg::ACT_LOAD, i, re, im);
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_valid || bin_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_direction(bit d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_direction <= d;
    do @(posedge clk); while (!cfg_ready);
    inv_dir = d;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Build the twiddle table by octant folding, same rounding as the ROM
  initial begin
    int q, r, rr, quarter;
    longint unsigned x;
    longint c, s;
    quarter = N_PTS / 4;
    for (int k = 0; k < N_PTS; k++) begin
      q = (k / quarter) % 4;
      r = k % quarter;
      rr = (2 * r <= quarter) ? r : quarter - r;
      x = (64'd2 * r2fft_pkg::PI_Q31 * rr + N_PTS / 2) / N_PTS;
      if (2 * r <= quarter) begin
        c = longint'((q31_series(x, 1) + 8192) >> 14);
        s = longint'((q31_series(x, 0) + 8192) >> 14);
      end else begin
        c = longint'((q31_series(x, 0) + 8192) >> 14);
        s = longint'((q31_series(x, 1) + 8192) >> 14);
      end
      case (q)
        0: begin tw_cos[k] = c;  tw_sin[k] = s;  end
        1: begin tw_cos[k] = -s; tw_sin[k] = c;  end
        2: begin tw_cos[k] = -c; tw_sin[k] = -s; end
        default: begin tw_cos[k] = s; tw_sin[k] = -c; end
      endcase
    end
    for (int i = 0; i < N_PTS; i++) begin
      spec_re[i] = 0;
      spec_im[i] = 0;
    end
  end

  // Stimulus: reset, inverse run on a full frame, then a forward run on its result after random loads
  initial begin
    int pick;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_direction(1'b1);

    // Directed: extremes, ignored code, reads before and after an inverse run
    load_frame(1'b1);
    push_op(ACT_NONE, 1023, SMAX, SMIN);
    push_op(r2fft_pkg::ACT_READ, 0, 0, 0);
    push_op(r2fft_pkg::ACT_READ, N_PTS - 1, 0, 0);
    push_op(r2fft_pkg::ACT_READ, 1, 0, 0);
    push_op(r2fft_pkg::ACT_RUN, 0, 0, 0);
    push_op(r2fft_pkg::ACT_READ, 0, 0, 0);
    push_op(r2fft_pkg::ACT_READ, 1, 0, 0);
    push_op(r2fft_pkg::ACT_READ, N_PTS / 2, 0, 0);
    push_op(r2fft_pkg::ACT_READ, N_PTS - 1, 0, 0);
    for (int i = 0; i < 60; i++) push_op(r2fft_pkg::ACT_READ, $urandom_range(0, 1023), 0, 0);
    wait_drained();

    // Random loads, reads and ignored codes, then a forward run
    write_direction(1'b0);
    repeat (30) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        push_op(r2fft_pkg::ACT_LOAD, $urandom_range(0, 1023), longint'($urandom),
                longint'($urandom));
      else if (pick < 95)
        push_op(r2fft_pkg::ACT_READ, $urandom_range(0, 1023), longint'($urandom),
                longint'($urandom));
      else
        push_op(ACT_NONE, $urandom_range(0, 1023), longint'($urandom),
                longint'($urandom));
    end
    push_op(r2fft_pkg::ACT_RUN, $urandom_range(0, 1023), 0, 0);
    for (int i = 0; i < 25; i++) push_op(r2fft_pkg::ACT_READ, $urandom_range(0, 1023), 0, 0);
    wait_drained();

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Record each input transfer and advance the frame model
  always @(posedge clk) begin
    fft_op_t took_op;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      took_op.action = in_action;
      took_op.index  = in_index;
      took_op.re     = in_sample_re;
      took_op.im     = in_sample_im;
      apply_fft_op(took_op);
    end
  end

  // Sender: advance after a transfer, idle at random outside a quiet window
  always @(negedge clk) begin
    fft_op_t op;
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_ops.size() != 0 &&
          ((ops_sent >= 300 && ops_sent < 600) || $urandom_range(0, 99) >= 9)) begin
        op = pending_ops.pop_front();
        ops_sent++;
        in_valid <= 1'b1;
        in_action <= op.action;
        in_index <= op.index;
        in_sample_re <= op.re;
        in_sample_im <= op.im;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, a quiet window, and one long hold-off
  always @(negedge clk) begin
    int hold_left;
    bit held_once;
    if (!held_once && bins_seen >= 40) begin
      held_once = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (bins_seen >= 50 && bins_seen < 68) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 9);
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    bin_res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      bins_seen++;
      if (bin_expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result re=%0d im=%0d done=%0b", $time,
                 out_bin_re, out_bin_im, out_done_res);
      end else begin
        exp_r = bin_expect_q.pop_front();
        if (out_bin_re !== exp_r.re) begin
          errors++;
          $display("%0t: bin_re expected %0d actual %0d", $time, exp_r.re, out_bin_re);
        end
        if (out_bin_im !== exp_r.im) begin
          errors++;
          $display("%0t: bin_im expected %0d actual %0d", $time, exp_r.im, out_bin_im);
        end
        if (out_done_res !== exp_r.done) begin
          errors++;
          $display("%0t: done_res expected %0b actual %0b", $time, exp_r.done,
                   out_done_res);
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
